/* design/skh_pkg.sv */
// ----------------------------------------------------------------------------
// skh_pkg: shared types and constants for the keyed hash unit
// Holds the configuration record, the job record that crosses the queue,
// the queue status group and the register index codes.
// ----------------------------------------------------------------------------
package skh_pkg;

   // initialization constants of the four lanes
   localparam logic [63:0] IV0 = 64'h736f6d6570736575;
   localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
   localparam logic [63:0] IV2 = 64'h6c7967656e657261;
   localparam logic [63:0] IV3 = 64'h7465646279746573;

   // finalization marker folded into lane two
   localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

   // register index codes
   localparam logic [1:0] CSR_KEY_LOW    = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH   = 2'd1;
   localparam logic [1:0] CSR_C_ROUNDS   = 2'd2;
   localparam logic [1:0] CSR_F_ROUNDS   = 2'd3;

   typedef struct packed {
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [3:0]  c_rounds;
      logic [3:0]  f_rounds;
   } cfg_type;

   // one absorb job: message word, snapshot of key and round counts
   typedef struct packed {
      logic [63:0] word;
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [3:0]  c_rounds;
      logic [3:0]  f_rounds;
      logic        load_key;
      logic        is_last;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_COMP,
      BK_FIN
   } back_state_type;

endpackage

/* design/skh_front.sv */
// ----------------------------------------------------------------------------
// skh_front: byte packer and job builder
// Packs accepted bytes little-endian into words, counts the length and
// pushes one job per full word and one for the closing word of a message.
// ----------------------------------------------------------------------------
module skh_front import skh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_byte_present,
   input  logic             req_last,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   output logic             q_push,
   output job_type          q_data
);

   logic [63:0] word_ff, word_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic        start_ff, start_in;
   logic        pend_ff, pend_in;

   logic        accept;
   logic [63:0] merged;
   logic [7:0]  len_next;

   // hold off input while the queue is full or a closing word waits
   assign req_stall = q_status.full | pend_ff;
   assign accept    = req_valid & ~req_stall;
   assign merged    = word_ff | ({56'd0, req_data_byte} << {pos_ff, 3'b000});
   assign len_next  = len_ff + 8'd1;

   // classify the item and build the job
   always_comb begin
      word_in         = word_ff;
      pos_in          = pos_ff;
      len_in          = len_ff;
      start_in        = start_ff;
      pend_in         = pend_ff;
      q_push          = 1'b0;
      q_data.word     = word_ff;
      q_data.key_low  = cfg.key_low;
      q_data.key_high = cfg.key_high;
      q_data.c_rounds = cfg.c_rounds;
      q_data.f_rounds = cfg.f_rounds;
      q_data.load_key = start_ff;
      q_data.is_last  = 1'b0;
      if (pend_ff) begin
         // closing word after a message that ended on a word boundary
         if (!q_status.full) begin
            q_push          = 1'b1;
            q_data.word     = {len_ff, 56'd0};
            q_data.load_key = 1'b0;
            q_data.is_last  = 1'b1;
            word_in         = '0;
            pos_in          = '0;
            len_in          = '0;
            start_in        = 1'b1;
            pend_in         = 1'b0;
         end
      end else if (accept) begin
         if (req_byte_present) begin
            len_in = len_next;
            if (pos_ff == 3'd7) begin
               // first job of the message carries the key load
               q_push   = 1'b1;
               q_data.word = merged;
               word_in  = '0;
               pos_in   = '0;
               start_in = 1'b0;
               pend_in  = req_last;
            end else if (req_last) begin
               q_push         = 1'b1;
               q_data.word    = merged | {len_next, 56'd0};
               q_data.is_last = 1'b1;
               word_in        = '0;
               pos_in         = '0;
               len_in         = '0;
               start_in       = 1'b1;
            end else begin
               word_in = merged;
               pos_in  = pos_ff + 3'd1;
            end
         end else if (req_last) begin
            q_push         = 1'b1;
            q_data.word    = word_ff | {len_ff, 56'd0};
            q_data.is_last = 1'b1;
            word_in        = '0;
            pos_in         = '0;
            len_in         = '0;
            start_in       = 1'b1;
         end
      end
   end

   // message state
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         pos_ff   <= '0;
         len_ff   <= '0;
         start_ff <= 1'b1;
         pend_ff  <= 1'b0;
      end else begin
         word_ff  <= word_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

/* design/skh_queue.sv */
// ----------------------------------------------------------------------------
// skh_queue: two-entry job queue
// Decouples the byte packer from the round engine.
// ----------------------------------------------------------------------------
module skh_queue import skh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  job_type          q_data,
   input  logic             q_pop,
   output job_type          q_head,
   output queue_status_type q_status
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_status.full      = (count_ff == 2'd2);
   assign q_status.not_empty = (count_ff != 2'd0);
   assign do_push            = q_push & ~q_status.full;
   assign do_pop             = q_pop & q_status.not_empty;
   assign q_head             = entries_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_data;
      end
   end

endmodule

/* design/skh_back.sv */
// ----------------------------------------------------------------------------
// skh_back: round engine
// Absorbs queued words with half a round per cycle, finalizes on the
// closing word and holds the digest in an output register.
// ----------------------------------------------------------------------------
module skh_back import skh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_digest
);

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } lanes_type;

   // first half of a round: two adds, rotate by 13, 16 and 32
   function automatic lanes_type half_a(input lanes_type l);
      logic [63:0] a0;
      logic [63:0] a2;
      lanes_type   r;
      a0   = l.v0 + l.v1;
      a2   = l.v2 + l.v3;
      r.v1 = {l.v1[50:0], l.v1[63:51]} ^ a0;
      r.v3 = {l.v3[47:0], l.v3[63:48]} ^ a2;
      r.v0 = {a0[31:0], a0[63:32]};
      r.v2 = a2;
      return r;
   endfunction

   // second half of a round: two adds, rotate by 17, 21 and 32
   function automatic lanes_type half_b(input lanes_type l);
      logic [63:0] a0;
      logic [63:0] a2;
      lanes_type   r;
      a2   = l.v2 + l.v1;
      a0   = l.v0 + l.v3;
      r.v1 = {l.v1[46:0], l.v1[63:47]} ^ a2;
      r.v3 = {l.v3[42:0], l.v3[63:43]} ^ a0;
      r.v2 = {a2[31:0], a2[63:32]};
      r.v0 = a0;
      return r;
   endfunction

   back_state_type state_ff, state_in;
   lanes_type      lanes_ff, lanes_in;
   logic [63:0]    word_ff, word_in;
   logic           last_ff, last_in;
   logic [3:0]     crnd_ff, crnd_in;
   logic [3:0]     frnd_ff, frnd_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_digest_ff, rsp_digest_in;

   logic           c_done, f_done, out_free;
   lanes_type      half_lanes, base_lanes;

   assign c_done     = (cnt_ff == {crnd_ff, 1'b0});
   assign f_done     = (cnt_ff == {frnd_ff, 1'b0});
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign half_lanes = cnt_ff[0] ? half_b(lanes_ff) : half_a(lanes_ff);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digest = rsp_digest_ff;

   // lanes at the start of a job: key-derived on a new message
   always_comb begin
      if (q_head.load_key) begin
         base_lanes.v0 = IV0 ^ q_head.key_low;
         base_lanes.v1 = IV1 ^ q_head.key_high;
         base_lanes.v2 = IV2 ^ q_head.key_low;
         base_lanes.v3 = IV3 ^ q_head.key_high;
      end else begin
         base_lanes = lanes_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.not_empty) state_in = BK_COMP;
         end
         BK_COMP: begin
            if (c_done) state_in = last_ff ? BK_FIN : BK_IDLE;
         end
         BK_FIN: begin
            if (f_done && out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop         = 1'b0;
      lanes_in      = lanes_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      crnd_in       = crnd_ff;
      frnd_in       = frnd_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_digest_in = rsp_digest_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.not_empty) begin
               q_pop       = 1'b1;
               lanes_in    = base_lanes;
               lanes_in.v3 = base_lanes.v3 ^ q_head.word;
               word_in     = q_head.word;
               last_in     = q_head.is_last;
               crnd_in     = q_head.c_rounds;
               frnd_in     = q_head.f_rounds;
               cnt_in      = '0;
            end
         end
         BK_COMP: begin
            if (c_done) begin
               lanes_in.v0 = lanes_ff.v0 ^ word_ff;
               if (last_ff) lanes_in.v2 = lanes_ff.v2 ^ FINAL_MARK;
               cnt_in = '0;
            end else begin
               lanes_in = half_lanes;
               cnt_in   = cnt_ff + 5'd1;
            end
         end
         BK_FIN: begin
            if (f_done) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_digest_in = lanes_ff.v0 ^ lanes_ff.v1 ^ lanes_ff.v2 ^ lanes_ff.v3;
               end
            end else begin
               lanes_in = half_lanes;
               cnt_in   = cnt_ff + 5'd1;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff      <= lanes_in;
      word_ff       <= word_in;
      last_ff       <= last_in;
      crnd_ff       <= crnd_in;
      frnd_ff       <= frnd_in;
      cnt_ff        <= cnt_in;
      rsp_digest_ff <= rsp_digest_in;
   end

endmodule

/* design/siphash_keyed_hash_unit.sv */
// ----------------------------------------------------------------------------
// siphash_keyed_hash_unit: keyed 64-bit hash over a byte stream
// Configuration registers, byte packer, job queue and round engine.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  data_byte, byte_present, last
//   rsp      out        rsp_valid/rsp_stall  digest
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// The packer takes one byte per cycle while req_stall is low; a message
// whose last byte completes a word needs a separate closing word. The round
// engine runs half a round per cycle; the job queue lets the packer go on
// taking bytes while the engine works. Reset is synchronous and clears
// the message state; no clearing pass. req_stall rises while the two-entry
// job queue is full or a closing word waits; a digest held by rsp_stall
// holds back only the next finalization.
// ----------------------------------------------------------------------------
module siphash_keyed_hash_unit import skh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   job_type          q_data, q_head;
   logic             q_push, q_pop;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_LOW:  cfg_in.key_low  = csr_write_data;
            CSR_KEY_HIGH: cfg_in.key_high = csr_write_data;
            CSR_C_ROUNDS: cfg_in.c_rounds = csr_write_data[3:0];
            CSR_F_ROUNDS: cfg_in.f_rounds = csr_write_data[3:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_low  <= '0;
         cfg_ff.key_high <= '0;
         cfg_ff.c_rounds <= 4'd2;
         cfg_ff.f_rounds <= 4'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   skh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (q_data)
   );

   skh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   skh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_digest (rsp_digest)
   );

   // never push a job into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_status.not_empty)
      else $error("job popped from empty queue");

   // a full queue must hold off the input
   assert property (@(posedge clock) disable iff (reset) q_status.full |-> req_stall)
      else $error("input open while queue full");

endmodule
